// ----- rtl/rfsp_pkg.sv -----
// shared types, constants and the channel frequency table for the rf synth programmer
package rfsp_pkg;

    localparam int FRAME_BITS        = 25;
    localparam int CHANNELS_PER_BAND = 8;
    localparam int CHAN_IDX_W        = 6;
    localparam int FREQ_W            = 13;
    localparam int PROD_W            = 18;
    localparam int DATA_W            = 20;
    localparam int ADDR_W            = 4;
    localparam int CNT_W             = 5;
    localparam int STEP_W            = 3;

    // multiplier constant, 1000 / 40
    localparam logic [4:0]        MUL_K       = 5'd25;
    localparam logic [STEP_W-1:0] MUL_LAST    = 3'd4;

    localparam logic [1:0] KIND_MHZ   = 2'd0;
    localparam logic [1:0] KIND_CHAN  = 2'd1;
    localparam logic [1:0] KIND_POWER = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_REF   = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_NA    = 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_POWER = 4'd7;

    localparam logic [DATA_W-1:0] REF_DIV_WORD = 20'd400;
    localparam logic [DATA_W-1:0] PA_WORD_ON   = 20'h04FBD;
    localparam logic [DATA_W-1:0] PA_PD_BIT    = 20'h00040;
    localparam logic [DATA_W-1:0] PA_PW_BITS   = 20'h00180;
    localparam logic [DATA_W-1:0] PA_BS_BITS   = 20'h00E00;
    localparam logic [DATA_W-1:0] PA_WORD_OFF  =
        (PA_WORD_ON | PA_PD_BIT) & ~(PA_PW_BITS | PA_BS_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_F0,
        ST_F1,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic                  load;
        logic                  final_frame;
        logic [FRAME_BITS-1:0] frame;
    } ser_cmd_t;

    // frame word, shifted out lsb first: address, write bit, data
    function automatic logic [FRAME_BITS-1:0] make_frame(
        input logic [ADDR_W-1:0] addr,
        input logic [DATA_W-1:0] data
    );
        make_frame = {data, 1'b1, addr};
    endfunction

    function automatic logic [FREQ_W-1:0] chan_freq(input logic [CHAN_IDX_W-1:0] idx);
        unique case (idx)
            6'd0:    chan_freq = 13'd5865;
            6'd1:    chan_freq = 13'd5845;
            6'd2:    chan_freq = 13'd5825;
            6'd3:    chan_freq = 13'd5805;
            6'd4:    chan_freq = 13'd5785;
            6'd5:    chan_freq = 13'd5765;
            6'd6:    chan_freq = 13'd5745;
            6'd7:    chan_freq = 13'd5725;
            6'd8:    chan_freq = 13'd5733;
            6'd9:    chan_freq = 13'd5752;
            6'd10:   chan_freq = 13'd5771;
            6'd11:   chan_freq = 13'd5790;
            6'd12:   chan_freq = 13'd5809;
            6'd13:   chan_freq = 13'd5828;
            6'd14:   chan_freq = 13'd5847;
            6'd15:   chan_freq = 13'd5866;
            6'd16:   chan_freq = 13'd5705;
            6'd17:   chan_freq = 13'd5685;
            6'd18:   chan_freq = 13'd5665;
            6'd19:   chan_freq = 13'd5645;
            6'd20:   chan_freq = 13'd5885;
            6'd21:   chan_freq = 13'd5905;
            6'd22:   chan_freq = 13'd5925;
            6'd23:   chan_freq = 13'd5945;
            6'd24:   chan_freq = 13'd5740;
            6'd25:   chan_freq = 13'd5760;
            6'd26:   chan_freq = 13'd5780;
            6'd27:   chan_freq = 13'd5800;
            6'd28:   chan_freq = 13'd5820;
            6'd29:   chan_freq = 13'd5840;
            6'd30:   chan_freq = 13'd5860;
            6'd31:   chan_freq = 13'd5880;
            6'd32:   chan_freq = 13'd5658;
            6'd33:   chan_freq = 13'd5695;
            6'd34:   chan_freq = 13'd5732;
            6'd35:   chan_freq = 13'd5769;
            6'd36:   chan_freq = 13'd5806;
            6'd37:   chan_freq = 13'd5843;
            6'd38:   chan_freq = 13'd5880;
            6'd39:   chan_freq = 13'd5917;
            default: chan_freq = '0;
        endcase
    endfunction

endpackage

// ----- rtl/rf_synth_serial_programmer_top.sv -----
// rf synthesizer serial programmer, top level with command sequencer and shared multiplier
//
// input channel: in_valid / in_stall carries one command word (kind, freq_mhz, band,
// channel, power_on). in_stall stays high from acceptance until the last serial bit
// of that command has been taken, so one command is in flight at a time.
// output channel: out_valid / out_stall carries one serial bit per word with
// frame_start, frame_end and last flags. each frame is 25 words.
// a frequency command (kind 0, or kind 1 through the channel table) runs a shift-and-add
// multiply by 25 on one adder, then sends the reference frame and the N/A frame.
// a power command (kind 2) sends one frame.
// kind 3 and a band at or above BAND_COUNT produce no words and free the input at once.
// the serializer shift register sets the output rate: one bit per cycle at best.
// when the receiver stalls, the current bit and its flags hold until taken.
// reset returns the sequencer to idle and drops out_valid; nothing is kept between
// commands.
module rf_synth_serial_programmer_top #(
    parameter int BAND_COUNT = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [12:0] freq_mhz,
    input  logic [2:0] band,
    input  logic [2:0] channel,
    input  logic       power_on,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       data_bit,
    output logic       frame_start,
    output logic       frame_end,
    output logic       last
);

    localparam logic [3:0] BAND_LIM = 4'(BAND_COUNT);

    rfsp_pkg::state_t                 state_reg, state_next;
    logic [rfsp_pkg::FREQ_W-1:0]      f_reg, f_next;
    logic [rfsp_pkg::PROD_W-1:0]      acc_reg, acc_next;
    logic [rfsp_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [rfsp_pkg::PROD_W-1:0]      addend;
    logic [rfsp_pkg::DATA_W-1:0]      na_word;
    rfsp_pkg::ser_cmd_t               cmd;
    logic                             ser_busy;
    logic                             in_take;

    assign in_stall = (state_reg != rfsp_pkg::ST_IDLE);
    assign in_take  = in_valid & ~in_stall;

    // one partial product per step of the shared adder
    assign addend  = rfsp_pkg::MUL_K[step_reg] ?
                     (rfsp_pkg::PROD_W'(f_reg) << step_reg) : '0;
    // N in bits 18:7, A in bits 5:0
    assign na_word = {1'b0, acc_reg[rfsp_pkg::PROD_W-1:6], 1'b0, acc_reg[5:0]};

    always_comb
    begin
        state_next      = state_reg;
        f_next          = f_reg;
        acc_next        = acc_reg;
        step_next       = step_reg;
        cmd.load        = 1'b0;
        cmd.final_frame = 1'b0;
        cmd.frame       = rfsp_pkg::make_frame(rfsp_pkg::ADDR_REF, rfsp_pkg::REF_DIV_WORD);
        unique case (state_reg)
            rfsp_pkg::ST_IDLE:
            begin
                acc_next  = '0;
                step_next = '0;
                if (in_take)
                begin
                    priority if (kind == rfsp_pkg::KIND_MHZ)
                    begin
                        f_next     = freq_mhz;
                        state_next = rfsp_pkg::ST_MUL;
                    end
                    else if (kind == rfsp_pkg::KIND_CHAN)
                    begin
                        // channel always fits the band with 3 bits, band limit covers table end
                        if ({1'b0, band} < BAND_LIM)
                        begin
                            f_next     = rfsp_pkg::chan_freq({band, channel});
                            state_next = rfsp_pkg::ST_MUL;
                        end
                    end
                    else if (kind == rfsp_pkg::KIND_POWER)
                    begin
                        cmd.load        = 1'b1;
                        cmd.final_frame = 1'b1;
                        cmd.frame       = rfsp_pkg::make_frame(rfsp_pkg::ADDR_POWER,
                                              power_on ? rfsp_pkg::PA_WORD_ON
                                                       : rfsp_pkg::PA_WORD_OFF);
                        state_next      = rfsp_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        state_next = rfsp_pkg::ST_IDLE;
                    end
                end
            end
            rfsp_pkg::ST_MUL:
            begin
                acc_next  = acc_reg + addend;
                step_next = step_reg + 1'b1;
                if (step_reg == rfsp_pkg::MUL_LAST)
                begin
                    state_next = rfsp_pkg::ST_F0;
                end
            end
            rfsp_pkg::ST_F0:
            begin
                cmd.load   = 1'b1;
                state_next = rfsp_pkg::ST_F1;
            end
            rfsp_pkg::ST_F1:
            begin
                if (!ser_busy)
                begin
                    cmd.load        = 1'b1;
                    cmd.final_frame = 1'b1;
                    cmd.frame       = rfsp_pkg::make_frame(rfsp_pkg::ADDR_NA, na_word);
                    state_next      = rfsp_pkg::ST_DRAIN;
                end
            end
            rfsp_pkg::ST_DRAIN:
            begin
                if (!ser_busy)
                begin
                    state_next = rfsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfsp_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg   <= f_next;
        acc_reg <= acc_next;
    end

    rfsp_ser u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .busy        (ser_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_bit    (data_bit),
        .frame_start (frame_start),
        .frame_end   (frame_end),
        .last        (last)
    );

    // input only opens once the serializer has finished the previous command
    a_idle_ser_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !ser_busy)
        else $error("input open while serializer busy");

    // a frame is never loaded over one still shifting
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !ser_busy)
        else $error("frame load while serializer busy");

    // the final bit of a command only appears while draining
    a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (state_reg == rfsp_pkg::ST_DRAIN))
        else $error("last bit outside drain state");

    // multiplier step counter stays within the constant's bits
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rfsp_pkg::ST_MUL) |-> (step_reg <= rfsp_pkg::MUL_LAST))
        else $error("multiplier step out of range");

    // after the multiply finishes the reference frame is loaded next cycle
    a_f0_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rfsp_pkg::ST_F0) |=> ser_busy)
        else $error("reference frame not loaded");

endmodule

// ----- rtl/rfsp_ser.sv -----
// frame serializer: loads one 25-bit frame and shifts it out one word per bit
module rfsp_ser (
    input  logic               clk,
    input  logic               rst_n,
    input  rfsp_pkg::ser_cmd_t cmd,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               data_bit,
    output logic               frame_start,
    output logic               frame_end,
    output logic               last
);

    localparam logic [rfsp_pkg::CNT_W-1:0] CNT_END = rfsp_pkg::CNT_W'(rfsp_pkg::FRAME_BITS - 1);

    logic [rfsp_pkg::FRAME_BITS-1:0] frame_reg, frame_next;
    logic [rfsp_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            final_reg, final_next;
    logic                            take;

    assign take = busy_reg & ~out_stall;

    always_comb
    begin
        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        final_next = final_reg;
        if (cmd.load && !busy_reg)
        begin
            frame_next = cmd.frame;
            cnt_next   = '0;
            busy_next  = 1'b1;
            final_next = cmd.final_frame;
        end
        else if (take)
        begin
            frame_next = frame_reg >> 1;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_END)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            final_reg <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign busy        = busy_reg;
    assign out_valid   = busy_reg;
    assign data_bit    = frame_reg[0];
    assign frame_start = (cnt_reg == '0);
    assign frame_end   = (cnt_reg == CNT_END);
    assign last        = final_reg & (cnt_reg == CNT_END);

endmodule

// ----- sim/rf_synth_serial_programmer_top_tb.sv -----
// self-checking testbench for the rf synth serial programmer top level
module rf_synth_serial_programmer_top_tb;

    localparam logic [1:0] K_MHZ    = rfsp_pkg::KIND_MHZ;
    localparam logic [1:0] K_CHAN   = rfsp_pkg::KIND_CHAN;
    localparam logic [1:0] K_POWER  = rfsp_pkg::KIND_POWER;
    localparam logic [1:0] K_UNUSED = 2'd3;

    localparam int BANDS          = 5;
    localparam int SLOTS_PER_BAND = 8;
    localparam int ITEMS          = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 80;
    localparam int LIMIT_CYCLES   = 500000;
    localparam int PRINT_CAP      = 30;

    localparam logic [3:0]  REG_REF      = 4'd0;
    localparam logic [3:0]  REG_NA       = 4'd1;
    localparam logic [3:0]  REG_POWER    = 4'd7;
    localparam logic [19:0] REF_DIV_DATA = 20'd400;
    localparam logic [19:0] PWR_ON_DATA  = 20'h04FBD;
    localparam logic [19:0] PWR_OFF_DATA = 20'h0407D;

    typedef struct packed {
        logic data_bit;
        logic frame_start;
        logic frame_end;
        logic last;
    } serial_bit_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = '0;
    logic [12:0] freq_mhz = '0;
    logic [2:0]  band = '0;
    logic [2:0]  channel = '0;
    logic        power_on = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        data_bit;
    logic        frame_start;
    logic        frame_end;
    logic        last;

    // channel frequencies in MHz, band-major
    int chan_mhz [0:39] = '{
        5865, 5845, 5825, 5805, 5785, 5765, 5745, 5725,
        5733, 5752, 5771, 5790, 5809, 5828, 5847, 5866,
        5705, 5685, 5665, 5645, 5885, 5905, 5925, 5945,
        5740, 5760, 5780, 5800, 5820, 5840, 5860, 5880,
        5658, 5695, 5732, 5769, 5806, 5843, 5880, 5917
    };

    serial_bit_t expected_bits [$];

    int error_count   = 0;
    int cmd_count     = 0;
    int dropped_count = 0;
    int bits_checked  = 0;
    int cycle_count   = 0;

    int   stall_pct    = 0;
    int   stall_run    = 0;
    int   hold_left    = 0;
    logic hold_pending = 1'b0;

    rf_synth_serial_programmer_top #(
        .BAND_COUNT(BANDS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .freq_mhz   (freq_mhz),
        .band       (band),
        .channel    (channel),
        .power_on   (power_on),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_bit   (data_bit),
        .frame_start(frame_start),
        .frame_end  (frame_end),
        .last       (last)
    );

    always #10 clk = ~clk;

    // ---------------- expected serial stream ----------------

    task automatic push_frame(input logic [3:0] addr, input logic [19:0] data,
                              input logic final_frame);
        logic [24:0] word;
        serial_bit_t sb;
        word = {data, 1'b1, addr};
        for (int b = 0; b < 25; b++)
        begin
            sb.data_bit    = word[b];
            sb.frame_start = (b == 0);
            sb.frame_end   = (b == 24);
            sb.last        = final_frame && (b == 24);
            expected_bits.push_back(sb);
        end
    endtask

    task automatic push_tuning(input int mhz);
        int scaled;
        int n_count;
        int a_count;
        logic [19:0] na_word;
        scaled  = mhz * 25;
        n_count = scaled / 64;
        a_count = scaled % 64;
        na_word = 20'((n_count << 7) | a_count);
        push_frame(REG_REF, REF_DIV_DATA, 1'b0);
        push_frame(REG_NA, na_word, 1'b1);
    endtask

    task automatic predict_command(input logic [1:0] k, input logic [12:0] f,
                                   input logic [2:0] b, input logic [2:0] c,
                                   input logic p);
        case (k)
            K_MHZ:
                push_tuning(int'(f));
            K_CHAN:
                if (int'(b) < BANDS && int'(c) < SLOTS_PER_BAND)
                    push_tuning(chan_mhz[int'(b) * SLOTS_PER_BAND + int'(c)]);
                else
                    dropped_count++;
            K_POWER:
                push_frame(REG_POWER, p ? PWR_ON_DATA : PWR_OFF_DATA, 1'b1);
            default:
                dropped_count++;
        endcase
    endtask

    // ---------------- sender side ----------------

    task automatic send_cmd(input logic [1:0] k, input logic [12:0] f,
                            input logic [2:0] b, input logic [2:0] c, input logic p);
        in_valid <= 1'b1;
        kind     <= k;
        freq_mhz <= f;
        band     <= b;
        channel  <= c;
        power_on <= p;
        do
            @(posedge clk);
        while (in_stall);
        predict_command(k, f, b, c, p);
        cmd_count++;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            kind     <= 2'($urandom);
            freq_mhz <= 13'($urandom);
            band     <= 3'($urandom);
            channel  <= 3'($urandom);
            power_on <= 1'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        do
            @(posedge clk);
        while (expected_bits.size() != 0);
    endtask

    // ---------------- receiver stall pattern ----------------

    always @(posedge clk)
    begin
        if (hold_pending)
        begin
            hold_pending <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (stall_pct == 0)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_run != 0)
        begin
            stall_run <= stall_run - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
            stall_run <= $urandom_range(0, 5);
        end
    end

    // ---------------- result checker ----------------

    task automatic report_field(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= PRINT_CAP)
                $error("%s mismatch: expected %0b, got %0b", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_bits
        serial_bit_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bits.size() == 0)
            begin
                error_count++;
                if (error_count <= PRINT_CAP)
                    $error("unexpected serial word: data_bit %0b start %0b end %0b last %0b",
                           data_bit, frame_start, frame_end, last);
            end
            else
            begin
                want = expected_bits.pop_front();
                bits_checked++;
                report_field("data_bit", want.data_bit, data_bit);
                report_field("frame_start", want.frame_start, frame_start);
                report_field("frame_end", want.frame_end, frame_end);
                report_field("last", want.last, last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_bits.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_freq_extremes();
        send_cmd(K_MHZ, 13'd0, 3'd7, 3'd7, 1'b1);
        send_cmd(K_MHZ, 13'd1, 3'd0, 3'd0, 1'b0);
        send_cmd(K_MHZ, 13'h1FFF, 3'd5, 3'd2, 1'b1);
        send_cmd(K_MHZ, 13'h1000, 3'd2, 3'd5, 1'b0);
        send_cmd(K_MHZ, 13'd5865, 3'd1, 3'd1, 1'b1);
        send_cmd(K_MHZ, 13'h0AAA, 3'd3, 3'd6, 1'b0);
        send_cmd(K_MHZ, 13'h1555, 3'd4, 3'd1, 1'b1);
    endtask

    task automatic test_band_channel();
        stall_pct <= 30;
        send_cmd(K_CHAN, 13'h1FFF, 3'd0, 3'd0, 1'b1);
        send_cmd(K_CHAN, 13'd0, 3'd4, 3'd7, 1'b0);
        send_cmd(K_CHAN, 13'h0F0F, 3'd2, 3'd5, 1'b1);
        send_cmd(K_CHAN, 13'd77, 3'd1, 3'd3, 1'b0);
        send_cmd(K_CHAN, 13'd4000, 3'd3, 3'd0, 1'b1);
    endtask

    task automatic test_power_word();
        send_cmd(K_POWER, 13'h1FFF, 3'd7, 3'd7, 1'b1);
        idle_cycles(3);
        send_cmd(K_POWER, 13'd0, 3'd0, 3'd0, 1'b0);
    endtask

    // commands the block drops (spare kind and bands past the table), then one power command
    task automatic test_dropped_commands();
        send_cmd(K_UNUSED, 13'h1FFF, 3'd7, 3'd7, 1'b1);
        send_cmd(K_CHAN, 13'd5000, 3'd5, 3'd0, 1'b1);
        send_cmd(K_UNUSED, 13'd0, 3'd0, 3'd0, 1'b0);
        send_cmd(K_CHAN, 13'd123, 3'd7, 3'd7, 1'b0);
        send_cmd(K_POWER, 13'd9, 3'd6, 3'd2, 1'b1);
    endtask

    task automatic test_random_traffic();
        int useful;
        int burst;
        int pick;
        logic [1:0]  k;
        logic [12:0] f;
        logic [2:0]  b;
        logic [2:0]  c;
        logic        p;
        logic        noise;
        useful = 0;
        while (useful < ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 20;
                2: stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                pick  = $urandom_range(0, 99);
                f     = ($urandom_range(0, 9) == 0) ? 13'h1FFF : 13'($urandom_range(0, 8191));
                b     = 3'($urandom_range(0, BANDS - 1));
                c     = 3'($urandom_range(0, 7));
                p     = 1'($urandom);
                noise = 1'b0;
                if (pick < 35)
                    k = K_MHZ;
                else if (pick < 70)
                    k = K_CHAN;
                else if (pick < 85)
                    k = K_POWER;
                else if (pick < 93)
                begin
                    k     = K_CHAN;
                    b     = 3'($urandom_range(BANDS, 7));
                    noise = 1'b1;
                end
                else
                begin
                    k     = K_UNUSED;
                    b     = 3'($urandom);
                    noise = 1'b1;
                end
                send_cmd(k, f, b, c, p);
                if (!noise)
                    useful++;
            end
            idle_cycles($urandom_range(0, 40));
        end
    endtask

    // receiver holds off long enough that the block backs up and stalls its input
    task automatic test_backpressure_fill();
        idle_cycles(1);
        wait_drain();
        stall_pct    <= 0;
        hold_pending <= 1'b1;
        send_cmd(K_MHZ, 13'($urandom_range(0, 8191)), 3'd0, 3'd0, 1'b0);
        send_cmd(K_POWER, 13'd0, 3'd0, 3'd0, 1'b1);
        send_cmd(K_CHAN, 13'd0, 3'($urandom_range(0, BANDS - 1)), 3'($urandom), 1'b0);
        send_cmd(K_MHZ, 13'h1FFF, 3'd0, 3'd0, 1'b0);
    endtask

    // sender stops until the output has fully drained, then resumes
    task automatic test_drain_pause();
        stall_pct <= 40;
        send_cmd(K_CHAN, 13'd0, 3'd4, 3'($urandom), 1'b0);
        send_cmd(K_POWER, 13'd0, 3'd0, 3'd0, 1'b0);
        idle_cycles(1);
        wait_drain();
        idle_cycles(30);
        send_cmd(K_MHZ, 13'($urandom_range(0, 8191)), 3'd0, 3'd0, 1'b0);
        send_cmd(K_CHAN, 13'd0, 3'd0, 3'($urandom), 1'b1);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_freq_extremes();
        test_band_channel();
        test_power_word();
        test_dropped_commands();
        test_random_traffic();
        test_backpressure_fill();
        test_drain_pause();

        idle_cycles(1);
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d commands sent, %0d dropped by the block, %0d serial words compared",
                 cmd_count, dropped_count, bits_checked);
        $display("tuning by MHz and by band/channel, power words, bursty input, output stalls");
        if (error_count == 0 && expected_bits.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
